@@ hw/rtl/fkvc_pkg.sv @@
// Package for the FIFO-replacement key-value cache.
// Holds sizes, the command code and the controller/datapath interface structs.
// No dependencies.
package fkvc_pkg;

  localparam int DEPTH    = 64;
  localparam int KEY_BITS = 64;

  localparam int SLOT_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int COUNT_W = $clog2(DEPTH + 1);
  localparam int CAP_W   = 7;
  localparam int KEY_W   = 64;
  localparam int VAL_W   = 32;

  localparam logic [CAP_W-1:0] CAP_RESET  = CAP_W'(64);
  localparam logic signed [VAL_W-1:0] MISS_VALUE = -32'sd1;

  typedef enum logic {
    CMD_GET = 1'b0,
    CMD_PUT = 1'b1
  } command_e;

  typedef struct packed {
    logic start;
    logic issue;
    logic finish;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic match;
    logic exhausted;
    logic out_free;
  } dp_stat_t;

endpackage

@@ hw/rtl/fifo_replacement_kv_cache.sv @@
// Top level of the fully associative key-value cache with FIFO replacement.
// Uses fkvc_pkg, fkvc_ctrl, fkvc_dpath.
//
//   channel  handshake                   word
//   in       in_valid_i / in_ready_o     command_i, key_i, value_i
//   out      out_valid_o / out_ready_i   found_o, read_value_o
//   cfg      cfg_we_i                    cfg_wdata_i (capacity)
//
// Each item is accepted in idle, then the held entries are scanned: all of them
// on a miss, up to the matching one on a hit; then finish and hand-off follow.
// The scan reads one entry per cycle through the read port of the key and value RAMs.
// Reset empties the table at once; the RAMs are not cleared.
// A full output register stalls only the hand-off step; the next word is taken after it.
module fifo_replacement_kv_cache
  import fkvc_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic                    command_i,
  input  logic [KEY_W-1:0]        key_i,
  input  logic signed [VAL_W-1:0] value_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic                    found_o,
  output logic signed [VAL_W-1:0] read_value_o,
  input  logic                    cfg_we_i,
  input  logic [CAP_W-1:0]        cfg_wdata_i
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  fkvc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  fkvc_dpath u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .command_i    (command_i),
    .key_i        (key_i),
    .value_i      (value_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .found_o      (found_o),
    .read_value_o (read_value_o)
  );

endmodule

@@ hw/rtl/fkvc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fkvc_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                           wdata_i,
  input  logic                                       re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                           rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/fkvc_dpath.sv @@
// Datapath of the key-value cache: item registers, key and value RAMs,
// FIFO pointers, capacity register and output word register. Uses fkvc_pkg, fkvc_ram.
module fkvc_dpath
  import fkvc_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  dp_cmd_t                 cmd_i,
  output dp_stat_t                stat_o,
  input  logic                    command_i,
  input  logic [KEY_W-1:0]        key_i,
  input  logic signed [VAL_W-1:0] value_i,
  input  logic                    cfg_we_i,
  input  logic [CAP_W-1:0]        cfg_wdata_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic                    found_o,
  output logic signed [VAL_W-1:0] read_value_o
);

  function automatic logic [SLOT_W-1:0] slot_add(input logic [SLOT_W-1:0]  base,
                                                 input logic [COUNT_W-1:0] off);
    logic [COUNT_W:0] sum;
    sum = (COUNT_W + 1)'(base) + (COUNT_W + 1)'(off);
    if (sum >= (COUNT_W + 1)'(DEPTH)) begin
      sum = sum - (COUNT_W + 1)'(DEPTH);
    end
    return sum[SLOT_W-1:0];
  endfunction

  command_e                cmd_q;
  logic [KEY_BITS-1:0]     key_q;
  logic signed [VAL_W-1:0] value_q;
  logic [CAP_W-1:0]        cap_q;
  logic [SLOT_W-1:0]       oldest_q, oldest_d;
  logic [COUNT_W-1:0]      count_q, count_d;
  logic [COUNT_W-1:0]      rank_q, rank_d;
  logic                    cmp_vld_q;
  logic [SLOT_W-1:0]       cmp_slot_q;
  logic                    res_found_q;
  logic signed [VAL_W-1:0] res_value_q;
  logic                    out_valid_q, out_valid_d;
  logic                    out_found_q;
  logic signed [VAL_W-1:0] out_value_q;

  logic [COUNT_W-1:0]  eff_cap;
  logic                evict;
  logic                match;
  logic [SLOT_W-1:0]   rd_addr;
  logic [SLOT_W-1:0]   append_slot;
  logic [KEY_BITS-1:0] key_rd;
  logic [VAL_W-1:0]    val_rd;
  logic                key_we;
  logic                val_we;
  logic [SLOT_W-1:0]   val_waddr;

  always_comb begin
    if (cap_q == '0) begin
      eff_cap = COUNT_W'(1);
    end else if (int'(cap_q) > DEPTH) begin
      eff_cap = COUNT_W'(DEPTH);
    end else begin
      eff_cap = COUNT_W'(cap_q);
    end
  end

  assign evict       = (count_q >= eff_cap);
  assign rd_addr     = slot_add(oldest_q, rank_q);
  assign append_slot = slot_add(oldest_q, count_q);
  assign match       = cmp_vld_q && (key_rd == key_q);

  assign stat_o.match     = match;
  assign stat_o.exhausted = (rank_q == count_q);
  assign stat_o.out_free  = !out_valid_q || out_ready_i;

  assign key_we    = cmd_i.finish && (cmd_q == CMD_PUT) && !match;
  assign val_we    = cmd_i.finish && (cmd_q == CMD_PUT);
  assign val_waddr = match ? cmp_slot_q : append_slot;

  fkvc_ram #(
    .Width (KEY_BITS),
    .Depth (DEPTH)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (append_slot),
    .wdata_i (key_q),
    .re_i    (cmd_i.issue),
    .raddr_i (rd_addr),
    .rdata_o (key_rd)
  );

  fkvc_ram #(
    .Width (VAL_W),
    .Depth (DEPTH)
  ) u_val_ram (
    .clk_i   (clk_i),
    .we_i    (val_we),
    .waddr_i (val_waddr),
    .wdata_i (value_q),
    .re_i    (cmd_i.issue),
    .raddr_i (rd_addr),
    .rdata_o (val_rd)
  );

  always_comb begin
    oldest_d = oldest_q;
    count_d  = count_q;
    if (key_we) begin
      if (evict) begin
        oldest_d = slot_add(oldest_q, COUNT_W'(1));
      end else begin
        count_d = count_q + COUNT_W'(1);
      end
    end
  end

  always_comb begin
    rank_d = rank_q;
    if (cmd_i.start) begin
      rank_d = '0;
    end else if (cmd_i.issue) begin
      rank_d = rank_q + COUNT_W'(1);
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= CAP_RESET;
      oldest_q    <= '0;
      count_q     <= '0;
      rank_q      <= '0;
      cmp_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      oldest_q    <= oldest_d;
      count_q     <= count_d;
      rank_q      <= rank_d;
      cmp_vld_q   <= cmd_i.issue;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      cmd_q   <= command_e'(command_i);
      key_q   <= key_i[KEY_BITS-1:0];
      value_q <= value_i;
    end
    if (cmd_i.issue) begin
      cmp_slot_q <= rd_addr;
    end
    if (cmd_i.finish) begin
      res_found_q <= match;
      if (cmd_q == CMD_GET) begin
        res_value_q <= match ? $signed(val_rd) : MISS_VALUE;
      end else begin
        res_value_q <= '0;
      end
    end
    if (cmd_i.load_out) begin
      out_found_q <= res_found_q;
      out_value_q <= res_value_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign found_o      = out_found_q;
  assign read_value_o = out_value_q;

endmodule

@@ hw/rtl/fkvc_ctrl.sv @@
// Controller of the key-value cache: accept, scan held entries, finish, hand off.
// Uses fkvc_pkg.
module fkvc_ctrl
  import fkvc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_FINISH
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (stat_i.match || stat_i.exhausted) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_FINISH;
        end else begin
          cmd_o.issue = 1'b1;
        end
      end
      ST_FINISH: begin
        if (stat_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);

endmodule

@@ hw/rtl/fkvc_checker.sv @@
// Port-level checker for the key-value cache, bound to the top level.
// Uses fkvc_pkg.
module fkvc_props
  import fkvc_pkg::*;
(
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_ready_o,
  input logic                    out_valid_o,
  input logic                    out_ready_i,
  input logic                    found_o,
  input logic signed [VAL_W-1:0] read_value_o
);

  a_one_word_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while a word is in flight");

  a_result_returns_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> in_ready_o)
    else $error("result shown without return to idle");

  a_miss_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |-> read_value_o == MISS_VALUE || read_value_o == '0)
    else $error("miss word carries a stored value");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(found_o)
      && $stable(read_value_o))
    else $error("stalled output word changed");

endmodule

bind fifo_replacement_kv_cache fkvc_props u_fkvc_props (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .found_o      (found_o),
  .read_value_o (read_value_o)
);

@@ tb/sv/fkvc_checker.sv @@
// Checker for fifo_replacement_kv_cache: watches the in, out and cfg ports,
// keeps its own copy of the table and compares every result word in order.
// Depends on fkvc_pkg.
module fkvc_checker
  import fkvc_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  input  logic                    in_ready_i,
  input  logic                    command_i,
  input  logic [KEY_W-1:0]        key_i,
  input  logic signed [VAL_W-1:0] value_i,
  input  logic                    out_valid_i,
  input  logic                    out_ready_i,
  input  logic                    found_i,
  input  logic signed [VAL_W-1:0] read_value_i,
  input  logic                    cfg_we_i,
  input  logic [CAP_W-1:0]        cfg_wdata_i,
  output int                      fail_count_o,
  output int                      outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [KEY_W-1:0] KEY_MASK = {KEY_W{1'b1}} >> (KEY_W - KEY_BITS);

  typedef struct packed {
    logic [KEY_W-1:0]        key;
    logic                    found;
    logic signed [VAL_W-1:0] read_value;
  } answer_t;

  logic [KEY_W-1:0] held_key [DEPTH];
  logic [VAL_W-1:0] held_val [DEPTH];
  int               head_slot;
  int               held_count;
  logic [CAP_W-1:0] capacity;
  answer_t          pending_answers [$];

  initial begin
    fail_count_o  = 0;
    outstanding_o = 0;
  end

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    fail_count_o++;
  endtask

  task automatic serve_request(input command_e cmd, input logic [KEY_W-1:0] raw_key,
                               input logic [VAL_W-1:0] wval, output answer_t ans);
    logic [KEY_W-1:0]  k;
    int                r;
    logic [SLOT_W-1:0] slot;
    logic [SLOT_W-1:0] hit_slot;
    int                room;
    bit                hit;
    k        = raw_key & KEY_MASK;
    hit      = 1'b0;
    hit_slot = '0;
    for (r = 0; r < held_count; r++) begin
      slot = SLOT_W'((head_slot + r) % DEPTH);
      if (!hit && held_key[slot] == k) begin
        hit      = 1'b1;
        hit_slot = slot;
      end
    end
    room = (capacity == 0) ? 1 : (capacity > DEPTH) ? DEPTH : int'(capacity);
    ans.key   = raw_key;
    ans.found = hit;
    if (cmd == CMD_GET) begin
      ans.read_value = hit ? held_val[hit_slot] : MISS_VALUE;
    end else begin
      ans.read_value = '0;
      if (hit) begin
        held_val[hit_slot] = wval;
      end else begin
        // drop the oldest entry once the table is at capacity
        if (held_count >= room && held_count > 0) begin
          head_slot = (head_slot + 1) % DEPTH;
          held_count--;
        end
        slot           = SLOT_W'((head_slot + held_count) % DEPTH);
        held_key[slot] = k;
        held_val[slot] = wval;
        held_count++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    answer_t want;
    answer_t got;
    if (!rst_ni) begin
      head_slot  = 0;
      held_count = 0;
      capacity   = CAP_RESET;
      pending_answers.delete();
    end else begin
      if (cfg_we_i) begin
        capacity = cfg_wdata_i;
      end
      if (out_valid_i && out_ready_i) begin
        if (pending_answers.size() == 0) begin
          report_mismatch($sformatf("result word with no request pending (found %0b value %0d)",
                                    found_i, read_value_i));
        end else begin
          want = pending_answers.pop_front();
          if (found_i !== want.found) begin
            report_mismatch($sformatf("key %h: found %b, want %b",
                                      want.key, found_i, want.found));
          end
          if (read_value_i !== want.read_value) begin
            report_mismatch($sformatf("key %h: read_value %0d, want %0d",
                                      want.key, read_value_i, want.read_value));
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        serve_request(command_e'(command_i), key_i, value_i, got);
        pending_answers.push_back(got);
      end
    end
    outstanding_o = pending_answers.size();
  end

endmodule

@@ tb/sv/tb_fifo_replacement_kv_cache.sv @@
// Testbench top for fifo_replacement_kv_cache: clock, reset, stimulus and verdict.
// Depends on fkvc_pkg, fifo_replacement_kv_cache and fkvc_checker.
module tb_fifo_replacement_kv_cache;
  timeunit 1ns;
  timeprecision 1ps;

  import fkvc_pkg::*;

  localparam int POOL_MAX   = 128;
  localparam int POOL_IDX_W = $clog2(POOL_MAX);

  logic                    clk_i = 1'b0;
  logic                    rst_ni;
  logic                    in_valid_i;
  logic                    in_ready_o;
  logic                    command_i;
  logic [KEY_W-1:0]        key_i;
  logic signed [VAL_W-1:0] value_i;
  logic                    out_valid_o;
  logic                    out_ready_i;
  logic                    found_o;
  logic signed [VAL_W-1:0] read_value_o;
  logic                    cfg_we_i;
  logic [CAP_W-1:0]        cfg_wdata_i;

  int               fail_count;
  int               outstanding;
  bit               hold_output = 1'b0;
  bit               steady_tail = 1'b0;
  logic [KEY_W-1:0] key_pool [POOL_MAX];

  fifo_replacement_kv_cache dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .command_i    (command_i),
    .key_i        (key_i),
    .value_i      (value_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .found_o      (found_o),
    .read_value_o (read_value_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  fkvc_checker kv_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .command_i     (command_i),
    .key_i         (key_i),
    .value_i       (value_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .found_i       (found_o),
    .read_value_i  (read_value_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding)
  );

  always #6 clk_i = ~clk_i;

  initial begin
    #8_000_000;
    $display("fifo_replacement_kv_cache verification failed");
    $finish;
  end

  initial begin
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (hold_output) begin
        out_ready_i <= 1'b0;
        repeat (300) @(posedge clk_i);
        hold_output = 1'b0;
        out_ready_i <= 1'b1;
      end else if (!steady_tail && $urandom_range(0, 7) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  task automatic send_word(input command_e cmd, input logic [KEY_W-1:0] k,
                           input logic [VAL_W-1:0] v);
    in_valid_i <= 1'b1;
    command_i  <= cmd;
    key_i      <= k;
    value_i    <= v;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (!steady_tail && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    while (outstanding != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic set_capacity(input logic [CAP_W-1:0] c);
    in_valid_i <= 1'b0;
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= c;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_phase(input int cap_value, input int n_items, input int pool_n,
                           input bit fresh_pool, input int put_pct, input int hold_at,
                           input int drain_at);
    logic [KEY_W-1:0] k;
    int               i;
    set_capacity(CAP_W'(cap_value));
    if (fresh_pool) begin
      for (i = 0; i < pool_n; i++) key_pool[POOL_IDX_W'(i)] = {$urandom, $urandom};
    end
    for (i = 0; i < n_items; i++) begin
      if (i == hold_at) begin
        hold_output = 1'b1;
      end
      if (i == drain_at) begin
        in_valid_i <= 1'b0;
        wait_drained();
      end
      if ($urandom_range(0, 4) == 0) begin
        k = {$urandom, $urandom};
      end else begin
        k = key_pool[POOL_IDX_W'($urandom_range(0, pool_n - 1))];
      end
      send_word(($urandom_range(1, 100) <= put_pct) ? CMD_PUT : CMD_GET, k, $urandom);
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    command_i   = CMD_GET;
    key_i       = '0;
    value_i     = '0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty table, then a single-entry table
    send_word(CMD_GET, '0, $urandom);
    set_capacity(CAP_W'(1));
    send_word(CMD_PUT, '0, 32'h8000_0000);
    send_word(CMD_GET, '0, $urandom);
    send_word(CMD_PUT, '1, 32'h7FFF_FFFF);
    send_word(CMD_GET, '0, $urandom);
    send_word(CMD_GET, '1, $urandom);
    send_word(CMD_PUT, '1, 32'hFFFF_FFFF);
    send_word(CMD_GET, '1, $urandom);
    // zero capacity behaves as one
    set_capacity(CAP_W'(0));
    send_word(CMD_PUT, 64'h8000_0000_0000_0000, 32'h0000_0000);
    send_word(CMD_GET, '1, $urandom);
    send_word(CMD_GET, 64'h8000_0000_0000_0000, $urandom);
    // capacity above the table depth
    set_capacity(CAP_W'(127));
    send_word(CMD_PUT, '0, 32'h8000_0000);
    send_word(CMD_GET, '0, $urandom);
    send_word(CMD_GET, 64'h0000_0000_0000_0001, $urandom);
    send_word(CMD_PUT, '0, 32'h7FFF_FFFF);
    send_word(CMD_GET, '0, $urandom);
    send_word(CMD_PUT, '1, 32'h5555_AAAA);
    send_word(CMD_GET, 64'h8000_0000_0000_0000, $urandom);
    send_word(CMD_GET, '1, $urandom);

    run_phase(2, 60, 4, 1'b1, 50, -1, -1);
    run_phase(3, 70, 6, 1'b1, 50, -1, -1);
    run_phase(8, 90, 12, 1'b1, 50, 40, -1);
    run_phase(64, 130, 90, 1'b1, 70, -1, -1);
    // lower capacity below the held count
    run_phase(5, 60, 90, 1'b0, 50, -1, -1);
    run_phase(127, 90, 100, 1'b1, 50, -1, 30);
    run_phase(100, 60, 70, 1'b1, 50, 20, -1);
    run_phase(1, 60, 3, 1'b1, 50, -1, -1);
    steady_tail = 1'b1;
    run_phase(64, 90, 20, 1'b1, 50, -1, -1);

    in_valid_i <= 1'b0;
    wait_drained();
    repeat (80) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("fifo_replacement_kv_cache verification clean");
    end else begin
      $display("fifo_replacement_kv_cache verification failed");
    end
    $finish;
  end

endmodule
